@@ design/dpfm_pkg.sv @@
package dpfm_pkg;

  // Request and result payloads
  typedef struct packed {
    logic [2:0]  proc_id;
    logic [11:0] page_number;
  } in_t;

  typedef struct packed {
    logic [5:0] frame;
    logic [1:0] status;
    logic [2:0] victim_process;
    logic [9:0] victim_page;
  } out_t;

  // Result status codes
  localparam logic [1:0] ST_HIT     = 2'd0;
  localparam logic [1:0] ST_FILL    = 2'd1;
  localparam logic [1:0] ST_REPLACE = 2'd2;
  localparam logic [1:0] ST_INVALID = 2'd3;

  // Owner of a frame: process and virtual page
  typedef struct packed {
    logic [2:0]  pid;
    logic [11:0] page;
  } owner_t;

  // Control from the sequencer to the frame allocator
  typedef struct packed {
    logic lookup;  // issue owner reads
    logic commit;  // write back a miss
  } alloc_ctl_t;

  // Allocator answer, valid the cycle after lookup
  typedef struct packed {
    logic   hit;
    logic   full;
    owner_t victim;
  } alloc_rsp_t;

endpackage

@@ design/dpfm_frame_alloc.sv @@
module dpfm_frame_alloc #(
  parameter int FRAMES = 64
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  dpfm_pkg::alloc_ctl_t        ctl,
  input  logic [$clog2(FRAMES)-1:0]   map_frame,
  input  dpfm_pkg::owner_t            req,
  output dpfm_pkg::alloc_rsp_t        rsp,
  output logic [$clog2(FRAMES)-1:0]   frame_sel
);
  import dpfm_pkg::*;

  localparam int FW = $clog2(FRAMES);
  localparam int UW = $clog2(FRAMES + 1);

  owner_t          owner_mem [FRAMES];
  owner_t          own_a_r;      // owner of the frame the page map points at
  owner_t          own_b_r;      // owner of the oldest frame
  logic [FW-1:0]   map_frame_r;
  logic [UW-1:0]   used_r;
  logic [UW-1:0]   used_nxt;
  logic [FW-1:0]   oldest_r;
  logic [FW-1:0]   oldest_nxt;
  logic            hit;
  logic            full;

  // A page map entry counts only if its frame is handed out and the frame
  // still names this page as owner.
  assign hit  = (UW'(map_frame_r) < used_r) && (own_a_r == req);
  assign full = (used_r == UW'(FRAMES));

  always_comb begin
    priority if (hit) begin
      frame_sel = map_frame_r;
    end else if (full) begin
      frame_sel = oldest_r;
    end else begin
      frame_sel = used_r[FW-1:0];
    end
  end

  assign rsp.hit    = hit;
  assign rsp.full   = full;
  assign rsp.victim = own_b_r;

  always_ff @(posedge clk) begin
    if (ctl.lookup) begin
      own_a_r     <= owner_mem[map_frame];
      own_b_r     <= owner_mem[oldest_r];
      map_frame_r <= map_frame;
    end
    if (ctl.commit && !hit) begin
      owner_mem[frame_sel] <= req;
    end
  end

  always_comb begin
    used_nxt   = used_r;
    oldest_nxt = oldest_r;
    if (ctl.commit && !hit) begin
      if (!full) begin
        used_nxt = used_r + UW'(1);
      end else if (oldest_r == FW'(FRAMES - 1)) begin
        oldest_nxt = '0;
      end else begin
        oldest_nxt = oldest_r + FW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r   <= '0;
      oldest_r <= '0;
    end else begin
      used_r   <= used_nxt;
      oldest_r <= oldest_nxt;
    end
  end

  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= UW'(FRAMES))
    else $error("frame count above frame total");

  a_oldest_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !full |-> oldest_r == '0)
    else $error("eviction pointer moved before all frames filled");

  a_fill_step: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.commit && !hit && !full) |=> used_r == $past(used_r) + UW'(1))
    else $error("fill did not advance frame count");

endmodule

@@ design/demand_paging_fifo_mapper.sv @@
// Demand-paging frame mapper with FIFO replacement. Each input transaction
// names a process and a virtual page; the block returns the physical frame
// holding it: a hit, a newly filled free frame, or (once every frame is
// taken) the oldest frame, reassigned, with the evicted process and page
// reported so software can swap it out. Out-of-range pages or processes
// return status invalid and change nothing. After reset the page map is
// cleared one entry per cycle, all PROCESSES*PAGES entries (8192 by
// default), with in_ready low throughout. The page map is read when a
// transaction is accepted, the frame owners in S_LOOK, and in S_DONE the
// result is decided, written back and loaded into the output register
// once that register is free; in_ready returns after the load, so a new
// transaction is accepted only once the last result is loaded. A finished
// result waits in the output register while the next transaction is
// accepted; if it is still waiting when the next decide is due, the decide
// stage holds and the input with it. A page map entry is trusted only if
// its frame is already handed out and that frame's owner entry names the
// same process and page, so entries left behind by evictions read as
// unmapped.
module demand_paging_fifo_mapper #(
  parameter int PAGES     = 1024,
  parameter int FRAMES    = 64,
  parameter int PROCESSES = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  dpfm_pkg::in_t    in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output dpfm_pkg::out_t   out_data
);
  import dpfm_pkg::*;

  localparam int FW        = $clog2(FRAMES);
  localparam int MAP_DEPTH = PROCESSES * PAGES;
  localparam int SW        = $clog2(MAP_DEPTH);

  // One-hot sequencer: clearing, idle, page map data ready, owner data ready
  typedef enum logic [3:0] {
    S_CLR  = 4'b0001,
    S_IDLE = 4'b0010,
    S_LOOK = 4'b0100,
    S_DONE = 4'b1000
  } state_t;

  state_t        state_r;
  state_t        state_nxt;

  // Page map: frame number per (process, page); validity comes from the
  // owner back-check in the allocator
  logic [FW-1:0] map_mem [MAP_DEPTH];
  logic [FW-1:0] map_rd_r;

  logic [SW-1:0] clr_addr_r;
  logic [SW-1:0] clr_addr_nxt;
  logic          clr_last;

  logic          accept;
  logic          load;
  logic [SW-1:0] slot_in;
  logic          item_ok;
  logic [SW-1:0] slot_r;
  owner_t        req_r;
  logic          item_ok_r;

  alloc_ctl_t    actl;
  alloc_rsp_t    arsp;
  logic [FW-1:0] frame_sel;

  logic          out_valid_r;
  out_t          out_data_r;
  out_t          result;

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;
  // Result register frees up this cycle or is already empty
  assign load     = (state_r == S_DONE) && (!out_valid_r || out_ready);

  assign slot_in = SW'(32'(in_data.proc_id) * PAGES + 32'(in_data.page_number));
  assign item_ok = ({1'b0, in_data.page_number} < 13'(PAGES)) &&
                   ({4'b0, in_data.proc_id} < 7'(PROCESSES));

  // Clearing pass walks the page map once after reset
  assign clr_last     = (clr_addr_r == SW'(MAP_DEPTH - 1));
  assign clr_addr_nxt = (state_r == S_CLR) ? clr_addr_r + SW'(1) : clr_addr_r;

  // Latch the transaction and start the page map read
  always_ff @(posedge clk) begin
    if (accept) begin
      map_rd_r   <= map_mem[slot_in];
      slot_r     <= slot_in;
      req_r.pid  <= in_data.proc_id;
      req_r.page <= in_data.page_number;
      item_ok_r  <= item_ok;
    end
    // A miss maps the page to the chosen frame; the evicted page drops out
    // on its own because its frame now names a different owner.
    if (state_r == S_CLR) begin
      map_mem[clr_addr_r] <= '0;
    end else if (load && item_ok_r && !arsp.hit) begin
      map_mem[slot_r] <= frame_sel;
    end
  end

  assign actl.lookup = (state_r == S_LOOK);
  assign actl.commit = load && item_ok_r;

  dpfm_frame_alloc #(
    .FRAMES (FRAMES)
  ) u_alloc (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (actl),
    .map_frame (map_rd_r),
    .req       (req_r),
    .rsp       (arsp),
    .frame_sel (frame_sel)
  );

  always_comb begin
    result = '0;
    priority if (!item_ok_r) begin
      result.status = ST_INVALID;
    end else if (arsp.hit) begin
      result.frame  = 6'(frame_sel);
      result.status = ST_HIT;
    end else if (!arsp.full) begin
      result.frame  = 6'(frame_sel);
      result.status = ST_FILL;
    end else begin
      result.frame          = 6'(frame_sel);
      result.status         = ST_REPLACE;
      result.victim_process = arsp.victim.pid;
      result.victim_page    = arsp.victim.page[9:0];
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLR:   if (clr_last) state_nxt = S_IDLE;
      S_IDLE:  if (accept) state_nxt = S_LOOK;
      S_LOOK:  state_nxt = S_DONE;
      S_DONE:  if (load) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_addr_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      clr_addr_r <= clr_addr_nxt;
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_accept_look: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> state_r == S_LOOK)
    else $error("accepted transaction did not start lookup");

  a_look_done: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_LOOK |=> state_r == S_DONE)
    else $error("lookup did not reach decide");

  a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && out_valid_r && !out_ready) |=>
      (state_r == S_DONE && out_valid_r))
    else $error("result loaded over a pending transaction");

  a_replace_full: assert property (@(posedge clk) disable iff (!rst_n)
    (load && item_ok_r && !arsp.hit && !arsp.full) |=> out_data_r.status == ST_FILL)
    else $error("free frame available but not filled");

endmodule

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 100ps

// Frame mapper testbench: a short opening sequence with hand-checked answers,
// then random paging traffic scored against an in-bench page table model.
module tb_top;
  import dpfm_pkg::*;

  localparam int PAGES       = 1024;
  localparam int FRAMES      = 64;
  localparam int PROCESSES   = 8;
  localparam int RAND_REQS   = 490;
  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_AT     = 150;  // result count at which the sink goes quiet
  localparam int HOLD_CYCLES = 300;  // length of that quiet stretch
  localparam int RECENT_MAX  = 96;   // a bit more than FRAMES, so reuse hits and refaults

  // One opening-sequence row: the request, and its answer when known by hand.
  typedef struct packed {
    in_t  req;
    bit   known;
    out_t res;
  } open_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t  in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;

  always #4 clk = ~clk;

  demand_paging_fifo_mapper #(
    .PAGES    (PAGES),
    .FRAMES   (FRAMES),
    .PROCESSES(PROCESSES)
  ) u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  // ---------------------------------------------------------------------------
  // Page table model. One valid bit and frame per (process, page); each frame
  // remembers who owns it so an eviction can unmap the old page.
  // ---------------------------------------------------------------------------
  bit         mapped       [PROCESSES*PAGES];
  logic [5:0] mapped_frame [PROCESSES*PAGES];
  in_t        owner_of     [FRAMES];
  int         filled_count = 0;
  logic [5:0] evict_ptr    = '0;  // 6 bits, so it wraps at FRAMES on its own

  out_t pending_frames[$];  // answers still owed by the block, oldest first
  in_t  recent[$];          // recently requested in-range pages, for reuse

  int errors       = 0;
  int results_seen = 0;
  int hits         = 0;
  int fills        = 0;
  int replaces     = 0;
  int invalids     = 0;
  int in_stalls    = 0;
  int cycles       = 0;
  bit steady_src   = 1'b0;   // sender offers back to back while set

  function automatic out_t map_page(input in_t req);
    out_t res;
    int   slot;
    int   vslot;
    res = '0;
    if (req.page_number >= PAGES || req.proc_id >= PROCESSES) begin
      res.status = ST_INVALID;  // out of range: nothing changes
      return res;
    end
    slot = int'(req.proc_id) * PAGES + int'(req.page_number);
    if (mapped[slot]) begin
      res.frame  = mapped_frame[slot];
      res.status = ST_HIT;
      return res;
    end
    if (filled_count < FRAMES) begin
      // free frames still left: hand them out in order
      res.frame  = 6'(filled_count);
      res.status = ST_FILL;
      filled_count++;
    end else begin
      // all taken: the oldest fill is the victim
      res.frame          = evict_ptr;
      res.status         = ST_REPLACE;
      res.victim_process = owner_of[evict_ptr].proc_id;
      res.victim_page    = owner_of[evict_ptr].page_number[9:0];
      vslot = int'(owner_of[evict_ptr].proc_id) * PAGES
            + int'(owner_of[evict_ptr].page_number);
      mapped[vslot] = 1'b0;
      evict_ptr++;
    end
    mapped[slot]          = 1'b1;
    mapped_frame[slot]    = res.frame;
    owner_of[res.frame]   = req;
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Source side. Valid goes up with the payload and stays until accepted; the
  // model steps at the accepting edge. Valid only drops when a gap follows, so
  // back-to-back transactions never see a low and high in the same step.
  // ---------------------------------------------------------------------------
  task automatic offer(input in_t req, input bit known, input out_t hand_res);
    int   gap;
    out_t res;
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (!in_ready);
    res = map_page(req);
    pending_frames.push_back(known ? hand_res : res);
    if (req.page_number < PAGES) begin
      recent.push_back(req);
      if (recent.size() > RECENT_MAX) void'(recent.pop_front());
    end
    gap = steady_src ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  function automatic open_row_t row(input int pid, input int page, input bit known,
                                    input int frame, input logic [1:0] status);
    open_row_t r;
    r.req.proc_id     = 3'(pid);
    r.req.page_number = 12'(page);
    r.known           = known;
    r.res             = '0;
    r.res.frame       = 6'(frame);
    r.res.status      = status;
    return r;
  endfunction

  // Mixed paging traffic: reuse of recent pages gives hits early and refaults
  // once they have been evicted; fresh pages drive fills and replacements;
  // some out-of-range requests and corner pages mixed in.
  function automatic in_t pick_request();
    in_t r;
    int  mode;
    mode = $urandom_range(0, 99);
    if (mode < 40 && recent.size() > 0) begin
      r = recent[$urandom_range(0, recent.size() - 1)];
    end else if (mode < 80) begin
      r.proc_id     = 3'($urandom_range(0, PROCESSES - 1));
      r.page_number = 12'($urandom_range(0, PAGES - 1));
    end else if (mode < 90) begin
      r.proc_id     = 3'($urandom);
      r.page_number = 12'($urandom_range(PAGES, 4095));
    end else begin
      r.proc_id     = $urandom_range(0, 1) ? 3'd7 : 3'd0;
      r.page_number = $urandom_range(0, 1) ? 12'(PAGES - 1) : 12'd0;
    end
    return r;
  endfunction

  initial begin
    open_row_t opening[$];
    open_row_t r;
    // known answers: the first fills go out in frame order from zero
    opening.push_back(row(0, 0,      1, 0, ST_FILL));
    opening.push_back(row(0, 0,      1, 0, ST_HIT));
    opening.push_back(row(7, 1023,   1, 1, ST_FILL));
    opening.push_back(row(7, 1024,   1, 0, ST_INVALID));  // first page past the end
    opening.push_back(row(0, 4095,   1, 0, ST_INVALID));
    opening.push_back(row(7, 4095,   1, 0, ST_INVALID));
    opening.push_back(row(0, 12'h800, 1, 0, ST_INVALID));
    opening.push_back(row(7, 1023,   1, 1, ST_HIT));
    opening.push_back(row(5, 12'h2AA, 1, 2, ST_FILL));
    opening.push_back(row(2, 12'h155, 1, 3, ST_FILL));
    opening.push_back(row(5, 0,      1, 4, ST_FILL));     // same page, other process
    opening.push_back(row(0, 1023,   1, 5, ST_FILL));
    opening.push_back(row(0, 0,      1, 0, ST_HIT));
    // the rest are scored by the model
    opening.push_back(row(3, 512,    0, 0, ST_HIT));
    opening.push_back(row(3, 512,    0, 0, ST_HIT));
    opening.push_back(row(6, 1,      0, 0, ST_HIT));
    opening.push_back(row(1, 511,    0, 0, ST_HIT));
    opening.push_back(row(4, 2048,   0, 0, ST_HIT));
    opening.push_back(row(6, 1,      0, 0, ST_HIT));
    opening.push_back(row(2, 12'h155, 0, 0, ST_HIT));

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (opening[i]) begin
      r = opening[i];
      offer(r.req, r.known, r.res);
    end

    for (int n = 0; n < RAND_REQS; n++) begin
      // every fourth block of 40 runs with no source gaps
      steady_src = ((n / 40) % 4) == 1;
      offer(pick_request(), 1'b0, '0);
    end
    in_valid <= 1'b0;

    while (pending_frames.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);

    $display("Covered %0d transactions: %0d hits, %0d fills, %0d replacements, %0d invalid",
             results_seen, hits, fills, replaces, invalids);
    $display("Input held off for %0d cycles, including a %0d-cycle sink stall",
             in_stalls, HOLD_CYCLES);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Sink side. A fresh stall per result, with stall-free stretches, and one
  // long hold so the block backs up into its input.
  // ---------------------------------------------------------------------------
  initial begin
    int stall;
    int taken;
    taken = 0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    out_ready <= 1'b1;
    forever begin
      do @(posedge clk); while (!out_valid);
      taken++;
      if (taken == HOLD_AT) stall = HOLD_CYCLES;
      else if (((taken / 50) % 3) == 2) stall = 0;
      else stall = $urandom_range(0, 17);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
        out_ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Scoreboard: every accepted result against the oldest owed answer.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    out_t want;
    if (rst_n && in_valid && !in_ready) in_stalls++;
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      case (out_data.status)
        ST_HIT:     hits++;
        ST_FILL:    fills++;
        ST_REPLACE: replaces++;
        default:    invalids++;
      endcase
      if (pending_frames.size() == 0) begin
        $error("unexpected result transaction: frame %0d status %0d",
               out_data.frame, out_data.status);
        errors++;
      end else begin
        want = pending_frames.pop_front();
        if (out_data.frame !== want.frame) begin
          $error("frame: expected %0d, actual %0d", want.frame, out_data.frame);
          errors++;
        end
        if (out_data.status !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, out_data.status);
          errors++;
        end
        if (out_data.victim_process !== want.victim_process) begin
          $error("victim_process: expected %0d, actual %0d",
                 want.victim_process, out_data.victim_process);
          errors++;
        end
        if (out_data.victim_page !== want.victim_page) begin
          $error("victim_page: expected %0d, actual %0d",
                 want.victim_page, out_data.victim_page);
          errors++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results owed", cycles, pending_frames.size());
      $display("Verification failed");
      $finish;
    end
  end

endmodule

@@ files.f @@
design/dpfm_pkg.sv
design/dpfm_frame_alloc.sv
design/demand_paging_fifo_mapper.sv
tb/sv/tb_top.sv
